### hdl/simple_regression_fstat_assert.svh
// assertion macros shared by the regression block
`ifndef SIMPLE_REGRESSION_FSTAT_ASSERT_SVH
`define SIMPLE_REGRESSION_FSTAT_ASSERT_SVH

// implication checked on every edge outside reset
`define SFS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sfs assertion failed");

// condition that must never hold outside reset
`define SFS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("sfs forbidden condition seen");

`endif

### hdl/sfs_pkg.sv
`timescale 1ns / 1ps
package sfs_pkg;

  localparam int unsigned MAX_SAMPLES_DEF = 4096;
  // wide enough for (n-2) * sxy^2 << 16 and sxx*syy << 32
  localparam int unsigned BIG_W = 192;
  localparam int unsigned OPB_W = 64;
  localparam int unsigned QUO_W = 33;
  localparam int unsigned F_W   = 32;

  typedef enum logic [1:0] {
    FIT_OK    = 2'd0,
    FIT_DEGEN = 2'd1,
    FIT_SAT   = 2'd2
  } fit_status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_XY,
    ST_XX,
    ST_YY,
    ST_CHK,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_M5,
    ST_M6,
    ST_M7,
    ST_M8,
    ST_M9,
    ST_DIV,
    ST_DONE
  } sfs_state_e;

  typedef struct packed {
    logic start;
    logic neg;
  } mul_ctl_t;

  function automatic logic [OPB_W-1:0] mag64(input logic [OPB_W-1:0] v);
    mag64 = v[OPB_W-1] ? (~v + OPB_W'(1)) : v;
  endfunction

endpackage

### hdl/sfs_mul.sv
`timescale 1ns / 1ps
module sfs_mul
  import sfs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mul_ctl_t         ctl_i,
  input  logic [BIG_W-1:0] a_i,
  input  logic [OPB_W-1:0] b_i,
  output logic             done_o,
  output logic [BIG_W-1:0] p_o
);

  logic             busy_q;
  logic             neg_q;
  logic [BIG_W-1:0] acc_q;
  logic [BIG_W-1:0] a_q;
  logic [OPB_W-1:0] b_q;

  assign done_o = busy_q && (b_q == '0);
  assign p_o    = neg_q ? (~acc_q + BIG_W'(1)) : acc_q;

  // shift-add, stops once the remaining multiplier bits are all zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (ctl_i.start) begin
      busy_q <= 1'b1;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      acc_q <= '0;
      a_q   <= a_i;
      b_q   <= b_i;
      neg_q <= ctl_i.neg;
    end else if (busy_q && (b_q != '0)) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= {a_q[BIG_W-2:0], 1'b0};
      b_q <= {1'b0, b_q[OPB_W-1:1]};
    end
  end

endmodule

### hdl/sfs_div.sv
`timescale 1ns / 1ps
module sfs_div
  import sfs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [BIG_W-1:0] num_i,
  input  logic [BIG_W-1:0] den_i,
  output logic             done_o,
  output logic [QUO_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(QUO_W + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [BIG_W-1:0] rem_q;
  logic [BIG_W-1:0] den_q;
  logic [QUO_W-1:0] quot_q;
  logic             ge;

  assign ge     = (rem_q >= den_q);
  assign done_o = busy_q && (cnt_q == '0);
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(QUO_W);
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  // restoring division, top step tests the divisor shifted by one less than the quotient width
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      den_q  <= den_i << (QUO_W - 1);
      quot_q <= '0;
    end else if (busy_q && (cnt_q != '0)) begin
      if (ge) begin
        rem_q <= rem_q - den_q;
      end
      quot_q <= {quot_q[QUO_W-2:0], ge};
      den_q  <= {1'b0, den_q[BIG_W-1:1]};
    end
  end

endmodule

### hdl/simple_regression_fstat.sv
`timescale 1ns / 1ps
// channel  | handshake               | payload
// in       | in_valid_i / in_stall_o | x_sample_i, y_sample_i, last_sample_i
// out      | out_valid_o/ out_stall_i| f_statistic_o, fit_status_o
// a sample takes 3 passes of the shared shift-add multiplier, each stepping through the
//   operand magnitude bit by bit (up to 16 bits)
// a closing sample adds a check state, up to nine multiplier passes, a divider run
//   and the output state
// in_stall_o stays high whenever the sequencer is not idle
// reset clears all sums; a result waits in the output register until taken
`include "simple_regression_fstat_assert.svh"
module simple_regression_fstat
  import sfs_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic signed [15:0] x_sample_i,
  input  logic signed [15:0] y_sample_i,
  input  logic              last_sample_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [F_W-1:0]    f_statistic_o,
  output logic [1:0]        fit_status_o
);

  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned AX_W  = 16 + CNT_W;
  localparam int unsigned AXX_W = 30 + CNT_W;
  localparam int unsigned AXY_W = 31 + CNT_W;

  sfs_state_e state_q, state_d;

  logic             launch_q;
  logic [CNT_W-1:0] count_q;
  logic [AX_W-1:0]  ax_q, ay_q;
  logic [AXY_W-1:0] axy_q;
  logic [AXX_W-1:0] axx_q, ayy_q;
  logic [15:0]      xs_q, ys_q;
  logic             last_q;
  logic [OPB_W-1:0] t_q, sxx_q, syy_q, sxy_q;
  logic [BIG_W-1:0] a_q, b_q, num_q;
  logic [F_W-1:0]   res_f_q, f_q;
  fit_status_e      res_st_q, st_q;
  logic             out_valid_q;

  mul_ctl_t         mul_ctl;
  logic [BIG_W-1:0] mul_a;
  logic [OPB_W-1:0] mul_b;
  logic             mul_done;
  logic [BIG_W-1:0] mul_p;
  logic             div_start, div_done;
  logic [QUO_W-1:0] div_q;

  logic             in_acc, out_free, is_mul;
  logic [OPB_W-1:0] xm, ym, axm, aym, axym, diff64, dmag;
  logic [BIG_W-1:0] bdiff;

  assign in_stall_o    = (state_q != ST_IDLE);
  assign in_acc        = in_valid_i && !in_stall_o;
  assign out_valid_o   = out_valid_q;
  assign f_statistic_o = f_q;
  assign fit_status_o  = st_q;
  assign out_free      = !out_valid_q || !out_stall_i;

  assign xm    = mag64({{(OPB_W-16){xs_q[15]}}, xs_q});
  assign ym    = mag64({{(OPB_W-16){ys_q[15]}}, ys_q});
  assign axm   = mag64({{(OPB_W-AX_W){ax_q[AX_W-1]}}, ax_q});
  assign aym   = mag64({{(OPB_W-AX_W){ay_q[AX_W-1]}}, ay_q});
  assign axym  = mag64({{(OPB_W-AXY_W){axy_q[AXY_W-1]}}, axy_q});
  assign diff64 = t_q - mul_p[OPB_W-1:0];
  assign dmag   = mag64(diff64);
  assign bdiff  = mul_p - a_q;

  sfs_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mul_ctl),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  sfs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (b_q),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (count_q < CNT_W'(MAX_SAMPLES)) begin
            state_d = ST_XY;
          end else if (last_sample_i) begin
            state_d = ST_CHK;
          end
        end
      end
      ST_XY: if (mul_done) state_d = ST_XX;
      ST_XX: if (mul_done) state_d = ST_YY;
      ST_YY: if (mul_done) state_d = last_q ? ST_CHK : ST_IDLE;
      ST_CHK: state_d = (count_q < CNT_W'(3)) ? ST_DONE : ST_M1;
      ST_M1: if (mul_done) state_d = ST_M2;
      ST_M2: if (mul_done) state_d = (diff64 == '0) ? ST_DONE : ST_M3;
      ST_M3: if (mul_done) state_d = ST_M4;
      ST_M4: if (mul_done) state_d = ST_M5;
      ST_M5: if (mul_done) state_d = ST_M6;
      ST_M6: if (mul_done) state_d = ST_M7;
      ST_M7: if (mul_done) state_d = ST_M8;
      ST_M8: if (mul_done) state_d = (bdiff == '0) ? ST_DONE : ST_M9;
      ST_M9: if (mul_done) state_d = ST_DIV;
      ST_DIV: if (div_done) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // operand selection for the shared multiplier
  always_comb begin
    mul_a       = '0;
    mul_b       = '0;
    mul_ctl.neg = 1'b0;
    is_mul      = 1'b1;
    unique case (state_q)
      ST_XY: begin
        mul_a       = BIG_W'(xm);
        mul_b       = ym;
        mul_ctl.neg = xs_q[15] ^ ys_q[15];
      end
      ST_XX: begin
        mul_a = BIG_W'(xm);
        mul_b = xm;
      end
      ST_YY: begin
        mul_a = BIG_W'(ym);
        mul_b = ym;
      end
      ST_M1: begin
        mul_a = BIG_W'(count_q);
        mul_b = OPB_W'(axx_q);
      end
      ST_M2: begin
        mul_a = BIG_W'(axm);
        mul_b = axm;
      end
      ST_M3: begin
        mul_a = BIG_W'(count_q);
        mul_b = OPB_W'(ayy_q);
      end
      ST_M4: begin
        mul_a = BIG_W'(aym);
        mul_b = aym;
      end
      ST_M5: begin
        mul_a       = BIG_W'(count_q);
        mul_b       = axym;
        mul_ctl.neg = axy_q[AXY_W-1];
      end
      ST_M6: begin
        mul_a       = BIG_W'(axm);
        mul_b       = aym;
        mul_ctl.neg = ax_q[AX_W-1] ^ ay_q[AX_W-1];
      end
      ST_M7: begin
        mul_a = BIG_W'(sxy_q);
        mul_b = sxy_q;
      end
      ST_M8: begin
        mul_a = BIG_W'(sxx_q);
        mul_b = syy_q;
      end
      ST_M9: begin
        mul_a = a_q;
        mul_b = OPB_W'(count_q) - OPB_W'(2);
      end
      default: is_mul = 1'b0;
    endcase
    mul_ctl.start = is_mul && !launch_q;
    div_start     = (state_q == ST_DIV) && !launch_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      launch_q    <= 1'b0;
      count_q     <= '0;
      ax_q        <= '0;
      ay_q        <= '0;
      axy_q       <= '0;
      axx_q       <= '0;
      ayy_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mul_ctl.start || div_start) begin
        launch_q <= 1'b1;
      end else if (mul_done || div_done) begin
        launch_q <= 1'b0;
      end
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_XY: if (mul_done) axy_q <= axy_q + mul_p[AXY_W-1:0];
        ST_XX: if (mul_done) axx_q <= axx_q + mul_p[AXX_W-1:0];
        ST_YY: begin
          if (mul_done) begin
            ayy_q   <= ayy_q + mul_p[AXX_W-1:0];
            ax_q    <= ax_q + {{(AX_W-16){xs_q[15]}}, xs_q};
            ay_q    <= ay_q + {{(AX_W-16){ys_q[15]}}, ys_q};
            count_q <= count_q + CNT_W'(1);
          end
        end
        ST_DONE: begin
          if (out_free) begin
            count_q     <= '0;
            ax_q        <= '0;
            ay_q        <= '0;
            axy_q       <= '0;
            axx_q       <= '0;
            ayy_q       <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers of the input samples and of the finishing sequence
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      xs_q   <= x_sample_i;
      ys_q   <= y_sample_i;
      last_q <= last_sample_i;
    end
    unique case (state_q)
      ST_CHK: begin
        res_f_q  <= '0;
        res_st_q <= FIT_DEGEN;
      end
      ST_M1, ST_M3, ST_M5: if (mul_done) t_q <= mul_p[OPB_W-1:0];
      ST_M2: if (mul_done) sxx_q <= diff64;
      ST_M4: if (mul_done) syy_q <= diff64;
      ST_M6: if (mul_done) sxy_q <= dmag;
      ST_M7: begin
        if (mul_done) begin
          a_q      <= mul_p;
          res_f_q  <= '1;
          res_st_q <= FIT_SAT;
        end
      end
      ST_M8: if (mul_done) b_q <= bdiff;
      ST_M9: if (mul_done) num_q <= mul_p << 16;
      ST_DIV: begin
        if (div_done && !div_q[QUO_W-1]) begin
          res_f_q  <= div_q[F_W-1:0];
          res_st_q <= FIT_OK;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          f_q  <= res_f_q;
          st_q <= res_st_q;
        end
      end
      default: ;
    endcase
  end

  `SFS_ASSERT(a_busy_stalls, clk_i, rst_ni, (state_q != ST_IDLE) |-> in_stall_o)
  `SFS_ASSERT(a_degen_zero, clk_i, rst_ni, (out_valid_o && (fit_status_o == FIT_DEGEN)) |-> (f_statistic_o == '0))
  `SFS_ASSERT(a_sat_max, clk_i, rst_ni, (out_valid_o && (fit_status_o == FIT_SAT)) |-> (f_statistic_o == '1))
  `SFS_ASSERT_NEVER(a_no_double_launch, clk_i, rst_ni, mul_ctl.start && div_start)

endmodule
